// File: hdl/siphash13_keyed_hash_unit_assert.svh
// Assertion macros for the keyed hash unit checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SIPHASH13_KEYED_HASH_UNIT_ASSERT_SVH
`define SIPHASH13_KEYED_HASH_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define SIPH13_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset only.
`define SIPH13_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/siph13_pkg.sv
// Shared types, constants and SipRound functions for the keyed hash unit.
// Used by every module of the unit; depends on nothing.
package siph13_pkg;

	localparam logic [63:0] SEED_A      = 64'h736f6d6570736575;
	localparam logic [63:0] SEED_B      = 64'h646f72616e646f6d;
	localparam logic [63:0] SEED_C      = 64'h6c7967656e657261;
	localparam logic [63:0] SEED_D      = 64'h7465646279746573;
	localparam logic [63:0] LOW7_MASK   = 64'h7F7F7F7F7F7F7F7F;
	localparam logic [63:0] OFFSET_GE_A = 64'h3F3F3F3F3F3F3F3F;
	localparam logic [63:0] OFFSET_GT_Z = 64'h2525252525252525;
	localparam logic [63:0] TOP_BITS    = 64'h8080808080808080;
	localparam logic [63:0] FINAL_XOR   = 64'h00000000000000ff;
	localparam logic [3:0]  FULL_COUNT  = 4'd8;
	localparam logic [7:0]  FULL_LENGTH = 8'd8;

	typedef enum logic [0:0] {
		REG_KEY_LOW  = 1'b0,
		REG_KEY_HIGH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} sip_state_t;

	// One input item after masking and case folding.
	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  count;
		logic        last;
	} item_t;

	// Hand-off from the absorb stage to the finalization pipeline.
	typedef struct packed {
		sip_state_t  st;
		logic [63:0] fin_block;
	} final_job_t;

	function automatic sip_state_t sip_round(input sip_state_t s);
		logic [63:0] a, b, c, d;
		sip_state_t r;
		a = s.v0;
		b = s.v1;
		c = s.v2;
		d = s.v3;
		a = a + b; b = {b[50:0], b[63:51]}; b = b ^ a;
		a = {a[31:0], a[63:32]};
		c = c + d; d = {d[47:0], d[63:48]}; d = d ^ c;
		a = a + d; d = {d[42:0], d[63:43]}; d = d ^ a;
		c = c + b; b = {b[46:0], b[63:47]}; b = b ^ c;
		c = {c[31:0], c[63:32]};
		r.v0 = a;
		r.v1 = b;
		r.v2 = c;
		r.v3 = d;
		return r;
	endfunction

	function automatic sip_state_t absorb(input sip_state_t s, input logic [63:0] m);
		sip_state_t t;
		t = s;
		t.v3 = t.v3 ^ m;
		t = sip_round(t);
		t.v0 = t.v0 ^ m;
		return t;
	endfunction

	function automatic sip_state_t seed(input logic [63:0] k0, input logic [63:0] k1);
		sip_state_t s;
		s.v0 = SEED_A ^ k0;
		s.v1 = SEED_B ^ k1;
		s.v2 = SEED_C ^ k0;
		s.v3 = SEED_D ^ k1;
		return s;
	endfunction

	// Sets bit 5 of every byte in the range 'A'..'Z'; no carry crosses a byte.
	function automatic logic [63:0] fold_lower(input logic [63:0] x);
		logic [63:0] low7, ge_a, gt_z, upper;
		low7  = x & LOW7_MASK;
		ge_a  = low7 + OFFSET_GE_A;
		gt_z  = low7 + OFFSET_GT_Z;
		upper = ge_a & ~gt_z & ~x & TOP_BITS;
		return x | (upper >> 2);
	endfunction

endpackage

// File: hdl/siph13_front.sv
// Input register of the keyed hash unit: count clamping, tail masking and
// ASCII case folding. Depends on siph13_pkg.
module siph13_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [63:0]         message_word,
	input  logic [3:0]          byte_count,
	input  logic                last,
	input  logic                mode,
	input  logic                advance,
	output logic                valid_s1,
	output siph13_pkg::item_t   item_s1
);

	logic              load;
	logic [3:0]        eff_count;
	logic [63:0]       masked;
	siph13_pkg::item_t item_next;

	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_comb begin
		// Non-final items always count as full words.
		if (!last || (byte_count >= siph13_pkg::FULL_COUNT)) begin
			eff_count = siph13_pkg::FULL_COUNT;
		end else begin
			eff_count = byte_count;
		end
		for (int i = 0; i < 8; i++) begin
			masked[8*i +: 8] = (4'(i) < eff_count) ? message_word[8*i +: 8] : 8'h00;
		end
		item_next.word  = mode ? siph13_pkg::fold_lower(masked) : masked;
		item_next.count = eff_count;
		item_next.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_next;
		end
	end

endmodule

// File: hdl/siph13_state.sv
// Key registers and running SipHash state: one SipRound per absorbed word,
// hand-off of final blocks to the finalization pipeline. Depends on siph13_pkg.
module siph13_state (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [63:0]               cfg_data,
	input  logic                      valid_s1,
	input  siph13_pkg::item_t         item_s1,
	input  logic                      fin_ready,
	output logic                      advance,
	output logic                      job_valid,
	output siph13_pkg::final_job_t    job
);

	logic [63:0]            key_low_q, key_high_q;
	logic [63:0]            new_key_low, new_key_high;
	siph13_pkg::sip_state_t v_q;
	siph13_pkg::sip_state_t absorbed;
	logic [7:0]             len_q;
	logic [7:0]             len_new;

	always_comb begin
		new_key_low  = key_low_q;
		new_key_high = key_high_q;
		unique case (siph13_pkg::cfg_reg_t'(cfg_index))
			siph13_pkg::REG_KEY_LOW:  new_key_low  = cfg_data;
			siph13_pkg::REG_KEY_HIGH: new_key_high = cfg_data;
		endcase
	end

	// A final item waits in the input register until the pipeline can take it.
	assign advance   = valid_s1 && (!item_s1.last || fin_ready);
	assign job_valid = valid_s1 && item_s1.last;

	assign absorbed = siph13_pkg::absorb(v_q, item_s1.word);
	assign len_new  = len_q + {4'b0000, item_s1.count};

	always_comb begin
		job.st = item_s1.count[3] ? absorbed : v_q;
		// A full final word is followed by an empty block carrying only the length.
		job.fin_block = {len_new, item_s1.count[3] ? 56'd0 : item_s1.word[55:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_we) begin
			key_low_q  <= new_key_low;
			key_high_q <= new_key_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= siph13_pkg::seed(64'd0, 64'd0);
			len_q <= '0;
		end else if (cfg_we) begin
			v_q   <= siph13_pkg::seed(new_key_low, new_key_high);
			len_q <= '0;
		end else if (advance) begin
			if (item_s1.last) begin
				v_q   <= siph13_pkg::seed(key_low_q, key_high_q);
				len_q <= '0;
			end else begin
				v_q   <= absorbed;
				len_q <= len_q + siph13_pkg::FULL_LENGTH;
			end
		end
	end

endmodule

// File: hdl/siph13_finish.sv
// Finalization pipeline: final block round, then three rounds, one per stage,
// and the digest output register. Depends on siph13_pkg.
module siph13_finish (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	input  siph13_pkg::final_job_t    job,
	output logic                      fin_ready,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [63:0]               digest
);

	logic                   valid_s2, valid_s3, valid_s4, valid_s5;
	siph13_pkg::final_job_t job_s2;
	siph13_pkg::sip_state_t st_s3, st_s4, st_s5;
	siph13_pkg::sip_state_t fin_st, last_st;
	logic                   rdy_out, rdy5, rdy4, rdy3, rdy2;
	logic                   out_valid_q;
	logic [63:0]            digest_q;

	// Each stage moves when it is empty or the stage after it moves.
	assign rdy_out   = !out_valid_q || !out_stall;
	assign rdy5      = !valid_s5 || rdy_out;
	assign rdy4      = !valid_s4 || rdy5;
	assign rdy3      = !valid_s3 || rdy4;
	assign rdy2      = !valid_s2 || rdy3;
	assign fin_ready = rdy2;

	always_comb begin
		fin_st    = siph13_pkg::absorb(job_s2.st, job_s2.fin_block);
		fin_st.v2 = fin_st.v2 ^ siph13_pkg::FINAL_XOR;
	end

	assign last_st = siph13_pkg::sip_round(st_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy2) begin
				valid_s2 <= job_valid;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy5) begin
				valid_s5 <= valid_s4;
			end
			if (rdy_out) begin
				out_valid_q <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && job_valid) begin
			job_s2 <= job;
		end
		if (rdy3 && valid_s2) begin
			st_s3 <= fin_st;
		end
		if (rdy4 && valid_s3) begin
			st_s4 <= siph13_pkg::sip_round(st_s3);
		end
		if (rdy5 && valid_s4) begin
			st_s5 <= siph13_pkg::sip_round(st_s4);
		end
		if (rdy_out && valid_s5) begin
			digest_q <= last_st.v0 ^ last_st.v1 ^ last_st.v2 ^ last_st.v3;
		end
	end

	assign out_valid = out_valid_q;
	assign digest    = digest_q;

endmodule

// File: hdl/siphash13_keyed_hash_unit.sv
// Streaming SipHash-1-3 unit. Throughput: one item per cycle, set by the single
// SipRound per word in the state register loop, while the input is not stalled.
// A final item passes the input register, the hand-off register, the final block
// round, two rounds and the last round into the output register; output stall delays it.
// Reset clears keys to zero, seeds the state from them and empties the pipeline.
module siphash13_keyed_hash_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] message_word,
	input  logic [3:0]  byte_count,
	input  logic        last,
	input  logic        mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest
);

	logic                   valid_s1;
	siph13_pkg::item_t      item_s1;
	logic                   advance;
	logic                   job_valid;
	siph13_pkg::final_job_t job;
	logic                   fin_ready;

	siph13_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.message_word (message_word),
		.byte_count   (byte_count),
		.last         (last),
		.mode         (mode),
		.advance      (advance),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	siph13_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.fin_ready (fin_ready),
		.advance   (advance),
		.job_valid (job_valid),
		.job       (job)
	);

	siph13_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.fin_ready (fin_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.digest    (digest)
	);

endmodule

// File: hdl/siph13_checker.sv
// Port-level checker for the keyed hash unit, bound to the top level.
// Depends on siphash13_keyed_hash_unit_assert.svh.
`include "siphash13_keyed_hash_unit_assert.svh"

module siph13_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] digest
);

	logic in_xfer;

	assign in_xfer = in_valid && !in_stall;

	`SIPH13_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "digest dropped under stall")
	`SIPH13_ASSERT_NXT(a_digest_stable, out_valid && out_stall, $stable(digest), "digest changed under stall")
	// Input stalls only when the whole finalization pipeline is backed up.
	`SIPH13_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without backpressure")
	// With the output never stalled, a final item's digest must be valid once it has passed the whole pipeline.
	`SIPH13_ASSERT_NXT(a_latency, (in_xfer && last && !out_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid, "digest late")

endmodule

bind siphash13_keyed_hash_unit siph13_checker u_siph13_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last      (last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.digest    (digest)
);
